FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk, off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/cdtp_pkg.sv
// ----------------------------------------------------------------------------
// cdtp_pkg
// Shared types, constants and functions of the CD-Text pack decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cdtp_pkg;

  localparam int PACK_LEN = 18;
  localparam int TEXT_LEN = 12;
  localparam int HOLD_LEN = 17;
  localparam int QDEPTH   = 2;

  localparam logic [7:0] MAX_TRACK     = 8'd99;
  localparam logic [7:0] CHARSET_ISO   = 8'd0;
  localparam logic [7:0] CHARSET_ASCII = 8'd1;

  localparam logic [1:0] PS_OK      = 2'd0;
  localparam logic [1:0] PS_SKIP    = 2'd1;
  localparam logic [1:0] PS_CRC     = 2'd2;
  localparam logic [1:0] PS_CHARSET = 2'd3;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic REG_CHARSET    = 1'b0;
  localparam logic REG_LAST_TRACK = 1'b1;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [4:0]  PTYPE_TEXT_HI = 5'b10000;

  typedef struct packed {
    logic                       has_pack;
    logic                       eor;
    logic [7:0]                 ptype;
    logic [7:0]                 trk1;
    logic [7:0]                 seq;
    logic [2:0]                 blk;
    logic                       crc_ok;
    logic [TEXT_LEN-1:0][7:0]   text;
  } pack_entry_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic has_store(input logic [2:0] ftype, input logic [7:0] trk);
    logic ok;
    ok = 1'b0;
    if (trk <= MAX_TRACK) begin
      if (ftype <= 3'd5) begin
        ok = 1'b1;
      end else if (ftype == 3'd7) begin
        ok = (trk == 8'd0);
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

FILE: sv/cdtp_front.sv
// ----------------------------------------------------------------------------
// cdtp_front
// Byte framer: collects 18-byte packs, runs the CRC, posts packs and
// end-of-read marks to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cdtp_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 in_eor,
  output logic                      push,
  output cdtp_pkg::pack_entry_t     push_entry,
  input  wire logic                 q_ready
);

  logic [4:0]  pos;
  logic [15:0] crc;
  logic [7:0]  hold [cdtp_pkg::HOLD_LEN];
  logic        accept;
  logic        at_end;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign at_end   = (pos == 5'(cdtp_pkg::PACK_LEN - 1));
  assign push     = accept && (at_end || in_eor);

  always_comb begin
    push_entry          = '0;
    push_entry.has_pack = at_end;
    push_entry.eor      = in_eor;
    push_entry.ptype    = hold[0];
    push_entry.trk1     = hold[1];
    push_entry.seq      = hold[2];
    push_entry.blk      = hold[3][6:4];
    push_entry.crc_ok   = (~crc == {hold[16], in_byte});
    for (int k = 0; k < cdtp_pkg::TEXT_LEN; k++) begin
      push_entry.text[k] = hold[k + 4];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !at_end) begin
      hold[pos] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      crc <= '0;
    end else if (accept) begin
      if (at_end || in_eor) begin
        pos <= '0;
        crc <= '0;
      end else begin
        pos <= pos + 5'd1;
        if (pos < 5'd16) begin
          crc <= cdtp_pkg::crc_feed(crc, in_byte);
        end
      end
    end
  end

  `ASSERT_ALWAYS(a_pos_range, pos <= 5'(cdtp_pkg::PACK_LEN - 1), "byte position out of range")

endmodule

`default_nettype wire

FILE: sv/cdtp_queue.sv
// ----------------------------------------------------------------------------
// cdtp_queue
// Two-entry queue of framed packs between framer and decoder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cdtp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  cdtp_pkg::pack_entry_t     push_entry,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 pop,
  output cdtp_pkg::pack_entry_t     out_entry
);

  cdtp_pkg::pack_entry_t mem [cdtp_pkg::QDEPTH];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;

  assign in_ready  = (cnt != 2'(cdtp_pkg::QDEPTH));
  assign out_valid = (cnt != 2'd0);
  assign out_entry = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  `ASSERT_ALWAYS(a_cnt_range, cnt <= 2'(cdtp_pkg::QDEPTH), "queue count overflow")
  `ASSERT_IMPLY(a_full_ptrs, cnt == 2'(cdtp_pkg::QDEPTH), wptr == rptr, "full queue pointers differ")

endmodule

`default_nettype wire

FILE: sv/cdtp_back.sv
// ----------------------------------------------------------------------------
// cdtp_back
// Pack decoder: checks a framed pack, walks its text bytes, tracks the
// current track per pack type and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cdtp_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [7:0]           charset_code,
  input  wire logic [6:0]           last_track_number,
  input  wire logic                 q_valid,
  output logic                      q_pop,
  input  cdtp_pkg::pack_entry_t     q_entry,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [23:0]               m_tdata,
  output logic                      m_tuser,
  output logic                      m_tlast
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHAR   = 4'b0010,
    ST_SECOND = 4'b0100,
    ST_STATUS = 4'b1000
  } state_t;

  state_t                               state;
  logic [cdtp_pkg::TEXT_LEN-1:0][7:0]   text;
  logic                                 eor;
  logic [2:0]                           ftype;
  logic [1:0]                           stat;
  logic [7:0]                           trk;
  logic [3:0]                           idx;
  logic [7:0]                           tpt [8];

  logic       emit_ok;
  logic       fire;
  logic [7:0] cur;
  logic [7:0] trk_inc;
  logic       last_idx;
  logic       cs_ok;
  logic       iso;

  assign emit_ok  = !m_tvalid || m_tready;
  assign cur      = text[idx];
  assign fire     = emit_ok && (state == ST_SECOND || state == ST_STATUS ||
                                (state == ST_CHAR && cur != 8'd0 &&
                                 cdtp_pkg::has_store(ftype, trk)));
  assign trk_inc  = (trk == 8'hFF) ? trk : trk + 8'd1;
  assign last_idx = (idx == 4'(cdtp_pkg::TEXT_LEN - 1));
  assign iso      = (charset_code == cdtp_pkg::CHARSET_ISO);
  assign cs_ok    = iso || (charset_code == cdtp_pkg::CHARSET_ASCII);
  assign q_pop    = q_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      text  <= q_entry.text;
      eor   <= q_entry.eor;
      ftype <= q_entry.ptype[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      idx      <= '0;
      trk      <= '0;
      stat     <= cdtp_pkg::PS_OK;
      for (int k = 0; k < 8; k++) begin
        tpt[k] <= '0;
      end
    end else begin
      m_tvalid <= fire || (m_tvalid && !m_tready);
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            idx <= '0;
            trk <= '0;
            if (!q_entry.has_pack) begin
              if (q_entry.eor) begin
                for (int k = 0; k < 8; k++) begin
                  tpt[k] <= '0;
                end
              end
            end else if (!cs_ok) begin
              stat  <= cdtp_pkg::PS_CHARSET;
              state <= ST_STATUS;
            end else if (q_entry.blk != 3'd0 ||
                         q_entry.ptype[7:3] != cdtp_pkg::PTYPE_TEXT_HI) begin
              stat  <= cdtp_pkg::PS_SKIP;
              state <= ST_STATUS;
            end else if (!q_entry.crc_ok) begin
              stat  <= cdtp_pkg::PS_CRC;
              state <= ST_STATUS;
            end else begin
              stat  <= cdtp_pkg::PS_OK;
              trk   <= (q_entry.seq == 8'd0) ? q_entry.trk1 : tpt[q_entry.ptype[2:0]];
              state <= ST_CHAR;
            end
          end
        end
        ST_CHAR: begin
          if (cur == 8'd0) begin
            trk <= trk_inc;
            if (trk_inc > {1'b0, last_track_number} || last_idx) begin
              state <= ST_STATUS;
            end else begin
              idx <= idx + 4'd1;
            end
          end else if (!cdtp_pkg::has_store(ftype, trk)) begin
            if (last_idx) begin
              state <= ST_STATUS;
            end else begin
              idx <= idx + 4'd1;
            end
          end else if (emit_ok) begin
            m_tuser  <= cdtp_pkg::KIND_CHAR;
            m_tlast  <= 1'b0;
            if (iso && cur[7]) begin
              m_tdata <= {3'b000, 6'b110000, cur[7:6], trk, ftype, cdtp_pkg::PS_OK};
              state   <= ST_SECOND;
            end else begin
              m_tdata <= {3'b000, cur, trk, ftype, cdtp_pkg::PS_OK};
              if (last_idx) begin
                state <= ST_STATUS;
              end else begin
                idx <= idx + 4'd1;
              end
            end
          end
        end
        ST_SECOND: begin
          if (emit_ok) begin
            m_tuser  <= cdtp_pkg::KIND_CHAR;
            m_tlast  <= 1'b0;
            m_tdata  <= {3'b000, 2'b10, cur[5:0], trk, ftype, cdtp_pkg::PS_OK};
            if (last_idx) begin
              state <= ST_STATUS;
            end else begin
              idx   <= idx + 4'd1;
              state <= ST_CHAR;
            end
          end
        end
        ST_STATUS: begin
          if (emit_ok) begin
            m_tuser  <= cdtp_pkg::KIND_STATUS;
            m_tlast  <= 1'b1;
            m_tdata  <= {3'b000, 8'd0, trk, ftype, stat};
            if (eor) begin
              for (int k = 0; k < 8; k++) begin
                tpt[k] <= '0;
              end
            end else if (stat == cdtp_pkg::PS_OK) begin
              tpt[ftype] <= trk;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLY(a_last_is_status, m_tvalid && m_tlast, m_tuser == cdtp_pkg::KIND_STATUS, "tlast")
  `ASSERT_IMPLY(a_idx_range, state != ST_IDLE, idx <= 4'(cdtp_pkg::TEXT_LEN - 1), "index range")

endmodule

`default_nettype wire

FILE: sv/cd_text_pack_decoder.sv
// ----------------------------------------------------------------------------
// Channel  Dir  Beat                       Fields (low bit up)
// s_axis   in   one stream byte            tdata: stream_byte[7:0]; tlast: end_of_read
// m_axis   out  one character or status    tdata: pack_status[1:0], field_code[4:2],
//                                           track_number[12:5], char_byte[20:13];
//                                           tuser: result_kind; tlast: last_of_pack
// cfg      in   register write             index 0 charset_code, 1 last_track_number
//
// The framer takes one byte per cycle while the pack queue (two packs) has room.
// The decoder picks up a pack, steps through its text bytes and emitted UTF-8
// bytes, then gives the status beat; it pops the next pack only after that beat.
// A stalled result register holds the decoder; the framer runs until the queue is full.
// Reset (synchronous) clears position, CRC, queue and per-type tracks.
// ----------------------------------------------------------------------------
// cd_text_pack_decoder
// CD-Text pack decoder with CRC check and ISO-8859-1 to UTF-8 expansion.
// ----------------------------------------------------------------------------
`default_nettype none

module cd_text_pack_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // stream_byte
  input  wire logic        s_tlast,   // end_of_read
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // pack_status, field_code, track_number, char_byte
  output logic             m_tuser,   // result_kind
  output logic             m_tlast,   // last_of_pack
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [7:0] charset_code;
  logic [6:0] last_track_number;

  logic                  push;
  logic                  q_ready;
  logic                  q_valid;
  logic                  q_pop;
  cdtp_pkg::pack_entry_t push_entry;
  cdtp_pkg::pack_entry_t q_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      charset_code      <= cdtp_pkg::CHARSET_ISO;
      last_track_number <= 7'(cdtp_pkg::MAX_TRACK);
    end else if (cfg_we) begin
      unique case (cfg_index)
        cdtp_pkg::REG_CHARSET:    charset_code      <= cfg_data;
        cdtp_pkg::REG_LAST_TRACK: last_track_number <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  cdtp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_eor     (s_tlast),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready)
  );

  cdtp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .in_ready   (q_ready),
    .out_valid  (q_valid),
    .pop        (q_pop),
    .out_entry  (q_entry)
  );

  cdtp_back u_back (
    .clk               (clk),
    .rst               (rst),
    .charset_code      (charset_code),
    .last_track_number (last_track_number),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_entry           (q_entry),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata),
    .m_tuser           (m_tuser),
    .m_tlast           (m_tlast)
  );

endmodule

`default_nettype wire
